@@ sv/flru_pkg.sv @@
// Package for the fully associative LRU cache model.
// Holds sizes, widths and the command and status types shared by the controller
// and the datapath. It depends on nothing.
package flru_pkg;

  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int TAG_W   = 16;
  localparam int CNT_W   = 32;
  localparam int WAYS_W  = 4;
  localparam int CMP_W   = (OCC_W > WAYS_W) ? OCC_W : WAYS_W;

  localparam logic [WAYS_W-1:0] WAYS_RESET = WAYS_W'(8);

  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic update;
  } flru_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic out_pending;
  } flru_sts_t;

endpackage

@@ sv/flru_if.sv @@
// Valid/ready channel interfaces for the request and the response words.
// Depends on flru_pkg for the field widths.
interface flru_req_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [flru_pkg::TAG_W-1:0]   block_index;

  modport source (output valid, func, block_index, input ready);
  modport sink   (input valid, func, block_index, output ready);
endinterface

interface flru_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic                         evicted_valid;
  logic [flru_pkg::TAG_W-1:0]   evicted_block;
  logic [flru_pkg::CNT_W-1:0]   hits_so_far;
  logic [flru_pkg::CNT_W-1:0]   misses_so_far;

  modport source (output valid, hit, evicted_valid, evicted_block, hits_so_far,
                  misses_so_far, input ready);
  modport sink   (input valid, hit, evicted_valid, evicted_block, hits_so_far,
                  misses_so_far, output ready);
endinterface

@@ sv/flru_ctrl.sv @@
// Controller for the LRU cache: sequences capture, lookup and update of one word.
// Depends on flru_pkg for the command and status types.
module flru_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic                rsp_ready_i,
  input  flru_pkg::flru_sts_t sts_i,
  output flru_pkg::flru_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o.lookup = !sts_i.is_clear;
        state_d      = S_UPDATE;
      end
      S_UPDATE: begin
        if (!sts_i.out_pending || rsp_ready_i) begin
          cmd_o.update = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/flru_dp.sv @@
// Datapath for the LRU cache: tags, valid bits, recency ranks, totals and the
// response register. Depends on flru_pkg and is driven by flru_ctrl.
module flru_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [flru_pkg::WAYS_W-1:0]   cfg_wdata_i,
  input  logic                          func_i,
  input  logic [flru_pkg::TAG_W-1:0]    block_index_i,
  input  logic                          rsp_ready_i,
  input  flru_pkg::flru_cmd_t           cmd_i,
  output flru_pkg::flru_sts_t           sts_o,
  output logic                          rsp_valid_o,
  output logic                          hit_o,
  output logic                          evicted_valid_o,
  output logic [flru_pkg::TAG_W-1:0]    evicted_block_o,
  output logic [flru_pkg::CNT_W-1:0]    hits_so_far_o,
  output logic [flru_pkg::CNT_W-1:0]    misses_so_far_o
);

  localparam int N = flru_pkg::ENTRIES;

  logic [flru_pkg::WAYS_W-1:0]  ways_q;
  logic                         func_q;
  logic [flru_pkg::TAG_W-1:0]   blk_q;
  logic [flru_pkg::TAG_W-1:0]   tag_q [N];
  logic [N-1:0]                 valid_q;
  logic [flru_pkg::RANK_W-1:0]  rank_q [N];
  logic [flru_pkg::CNT_W-1:0]   hit_tot_q, miss_tot_q;

  logic                         lk_hit_q, lk_fill_q;
  logic [flru_pkg::IDX_W-1:0]   lk_slot_q, lk_free_q;
  logic [flru_pkg::RANK_W-1:0]  lk_rank_q;

  logic                         out_valid_q, out_hit_q, out_ev_q;
  logic [flru_pkg::TAG_W-1:0]   out_blk_q;
  logic [flru_pkg::CNT_W-1:0]   out_hits_q, out_miss_q;

  logic                         lk_hit_d, lk_fill_d;
  logic [flru_pkg::IDX_W-1:0]   lk_slot_d, lk_free_d, victim;
  logic [flru_pkg::RANK_W-1:0]  lk_rank_d, best;
  logic                         found, free_found;
  logic [flru_pkg::OCC_W-1:0]   used;
  logic [flru_pkg::CMP_W-1:0]   used_ext, ways_ext;
  logic [flru_pkg::CNT_W-1:0]   hit_tot_d, miss_tot_d;

  // Lookup: tag compare, occupancy, first free entry and the least recent entry.
  always_comb begin
    lk_hit_d   = 1'b0;
    lk_slot_d  = '0;
    free_found = 1'b0;
    lk_free_d  = '0;
    found      = 1'b0;
    victim     = '0;
    best       = '0;
    used       = flru_pkg::OCC_W'($countones(valid_q));
    for (int i = 0; i < N; i++) begin
      if (valid_q[i] && !lk_hit_d && tag_q[i] == blk_q) begin
        lk_hit_d  = 1'b1;
        lk_slot_d = flru_pkg::IDX_W'(i);
      end
      if (!valid_q[i] && !free_found) begin
        free_found = 1'b1;
        lk_free_d  = flru_pkg::IDX_W'(i);
      end
      if (valid_q[i] && (!found || rank_q[i] > best)) begin
        found  = 1'b1;
        best   = rank_q[i];
        victim = flru_pkg::IDX_W'(i);
      end
    end
    used_ext = flru_pkg::CMP_W'(used);
    ways_ext = flru_pkg::CMP_W'(ways_q);
    if (ways_ext == '0) begin
      ways_ext = flru_pkg::CMP_W'(1);
    end else if (ways_ext > flru_pkg::CMP_W'(N)) begin
      ways_ext = flru_pkg::CMP_W'(N);
    end
    lk_fill_d = used_ext < ways_ext;
    lk_rank_d = lk_hit_d ? rank_q[lk_slot_d] : best;
    if (!lk_hit_d && !lk_fill_d) begin
      lk_slot_d = victim;
    end
  end

  always_comb begin
    hit_tot_d  = hit_tot_q;
    miss_tot_d = miss_tot_q;
    if (func_q == flru_pkg::FUNC_CLEAR) begin
      hit_tot_d  = '0;
      miss_tot_d = '0;
    end else if (lk_hit_q) begin
      if (hit_tot_q != '1) hit_tot_d = hit_tot_q + flru_pkg::CNT_W'(1);
    end else begin
      if (miss_tot_q != '1) miss_tot_d = miss_tot_q + flru_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i;
      blk_q  <= block_index_i;
    end
    if (cmd_i.lookup) begin
      lk_slot_q <= lk_slot_d;
      lk_free_q <= lk_free_d;
      lk_rank_q <= lk_rank_d;
    end
    if (cmd_i.update && func_q == flru_pkg::FUNC_ACCESS && !lk_hit_q) begin
      if (lk_fill_q) begin
        tag_q[lk_free_q] <= blk_q;
      end else begin
        tag_q[lk_slot_q] <= blk_q;
      end
    end
    if (cmd_i.update) begin
      out_hit_q  <= (func_q == flru_pkg::FUNC_ACCESS) && lk_hit_q;
      out_ev_q   <= (func_q == flru_pkg::FUNC_ACCESS) && !lk_hit_q && !lk_fill_q;
      out_blk_q  <= ((func_q == flru_pkg::FUNC_ACCESS) && !lk_hit_q && !lk_fill_q) ?
                    tag_q[lk_slot_q] : '0;
      out_hits_q <= hit_tot_d;
      out_miss_q <= miss_tot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ways_q      <= flru_pkg::WAYS_RESET;
      valid_q     <= '0;
      hit_tot_q   <= '0;
      miss_tot_q  <= '0;
      lk_hit_q    <= 1'b0;
      lk_fill_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) rank_q[i] <= '0;
    end else begin
      if (cfg_we_i) ways_q <= cfg_wdata_i;
      if (cmd_i.lookup) begin
        lk_hit_q  <= lk_hit_d;
        lk_fill_q <= lk_fill_d;
      end
      if (cmd_i.update) begin
        out_valid_q <= 1'b1;
        hit_tot_q   <= hit_tot_d;
        miss_tot_q  <= miss_tot_d;
        if (func_q == flru_pkg::FUNC_CLEAR) begin
          valid_q <= '0;
          for (int i = 0; i < N; i++) rank_q[i] <= '0;
        end else if (!lk_hit_q && lk_fill_q) begin
          for (int i = 0; i < N; i++) begin
            if (valid_q[i]) rank_q[i] <= rank_q[i] + flru_pkg::RANK_W'(1);
          end
          valid_q[lk_free_q] <= 1'b1;
          rank_q[lk_free_q]  <= '0;
        end else begin
          // A hit or an eviction makes the slot the most recent; younger
          // entries age by one.
          for (int i = 0; i < N; i++) begin
            if (valid_q[i] && flru_pkg::IDX_W'(i) != lk_slot_q && rank_q[i] < lk_rank_q) begin
              rank_q[i] <= rank_q[i] + flru_pkg::RANK_W'(1);
            end
          end
          rank_q[lk_slot_q] <= '0;
        end
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.is_clear    = func_q;
  assign sts_o.out_pending = out_valid_q;
  assign rsp_valid_o       = out_valid_q;
  assign hit_o             = out_hit_q;
  assign evicted_valid_o   = out_ev_q;
  assign evicted_block_o   = out_blk_q;
  assign hits_so_far_o     = out_hits_q;
  assign misses_so_far_o   = out_miss_q;

endmodule

@@ sv/fully_associative_lru_cache.sv @@
// Top level of the fully associative LRU cache hit/miss model.
// Depends on flru_pkg, flru_if, flru_ctrl and flru_dp.
//
//   port         dir   role
//   req_i        in    request word: func, block_index
//   rsp_o        out   response word: hit, eviction, running totals
//   cfg_we_i     in    write strobe for ways_in_use (cfg_wdata_i)
//
// Each word is handled in order: capture, lookup over all entries, update.
// A new request is taken only once the previous word has finished its update.
// The update waits while an earlier response is still held and not taken.
// Reset empties the cache, zeroes both totals and sets ways_in_use to eight.
module fully_associative_lru_cache (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [flru_pkg::WAYS_W-1:0]  cfg_wdata_i,
  flru_req_if.sink                     req_i,
  flru_rsp_if.source                   rsp_o
);

  flru_pkg::flru_cmd_t cmd;
  flru_pkg::flru_sts_t sts;

  flru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  flru_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (req_i.func),
    .block_index_i   (req_i.block_index),
    .rsp_ready_i     (rsp_o.ready),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .rsp_valid_o     (rsp_o.valid),
    .hit_o           (rsp_o.hit),
    .evicted_valid_o (rsp_o.evicted_valid),
    .evicted_block_o (rsp_o.evicted_block),
    .hits_so_far_o   (rsp_o.hits_so_far),
    .misses_so_far_o (rsp_o.misses_so_far)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("request taken while a word is in progress");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.hit |-> !rsp_o.evicted_valid)
    else $error("hit reported together with an eviction");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.evicted_valid |-> rsp_o.evicted_block == '0)
    else $error("evicted block not zero without an eviction");

endmodule
